/* rtl/window5_median_mean_filter_macros.svh */
`ifndef WINDOW5_MEDIAN_MEAN_FILTER_MACROS_SVH
`define WINDOW5_MEDIAN_MEAN_FILTER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define WMMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define WMMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wmmf_pkg.sv */
package wmmf_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    last;
    } t_in_item;

    typedef struct packed {
        t_sample filtered;
        logic    final_res;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_MEAN   = 1'b1;

endpackage

/* rtl/wmmf_window.sv */
`include "window5_median_mean_filter_macros.svh"

module wmmf_window #(
    parameter int WINDOW = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_load,
    input  wmmf_pkg::t_in_item                   i_in,
    output wmmf_pkg::t_stage_ctl                 o_ctl,
    output wmmf_pkg::t_sample [WINDOW-1:0]       o_win
);

    localparam int HIST_D = WINDOW - 1;
    localparam int CNT_W  = $clog2(WINDOW);

    wmmf_pkg::t_sample               r_hist [HIST_D];
    logic [CNT_W-1:0]                r_count;
    logic                            full;
    logic                            r_valid;
    logic                            r_last;
    wmmf_pkg::t_sample [WINDOW-1:0]  r_win;

    assign full = (r_count == CNT_W'(HIST_D));

    // history of previous samples, oldest at index 0
    always_ff @(posedge i_clk) begin
        if (i_load && !i_in.last) begin
            if (full) begin
                for (int j = 0; j < HIST_D - 1; j++) begin
                    r_hist[j] <= r_hist[j+1];
                end
                r_hist[HIST_D-1] <= i_in.sample;
            end else begin
                for (int j = 0; j < HIST_D; j++) begin
                    if (CNT_W'(j) == r_count) begin
                        r_hist[j] <= i_in.sample;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_load) begin
            if (i_in.last) begin
                r_count <= '0;
            end else if (!full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_load && full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last <= i_in.last;
            for (int j = 0; j < HIST_D; j++) begin
                r_win[j] <= r_hist[j];
            end
            r_win[WINDOW-1] <= i_in.sample;
        end
    end

    assign o_ctl = '{valid: r_valid, last: r_last};
    assign o_win = r_win;

    `WMMF_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(HIST_D), "history count overflow")
    `WMMF_ASSERT_NEXT(a_last_clears, i_load && i_in.last, r_count == '0, "count not cleared")
    `WMMF_ASSERT_NEXT(a_short_no_window, i_en && !(i_load && full), !r_valid,
        "window issued before history full")

endmodule

/* rtl/wmmf_stats.sv */
module wmmf_stats #(
    parameter int WINDOW = 5
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  wmmf_pkg::t_stage_ctl                    i_ctl,
    input  wmmf_pkg::t_sample [WINDOW-1:0]          i_win,
    output wmmf_pkg::t_stage_ctl                    o_ctl,
    output wmmf_pkg::t_sample                       o_median,
    output logic [wmmf_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] o_abs_sum,
    output logic                                    o_sum_neg
);

    localparam int SUM_W = wmmf_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int RNK_W = $clog2(WINDOW + 1);
    localparam logic [RNK_W-1:0] HALF = RNK_W'(WINDOW / 2);

    logic [RNK_W-1:0]         n_lt [WINDOW];
    logic [RNK_W-1:0]         n_gt [WINDOW];
    logic [WINDOW-1:0]        is_mid;
    wmmf_pkg::t_sample        median;
    logic signed [SUM_W-1:0]  sum;
    logic                     r_valid;
    logic                     r_last;
    wmmf_pkg::t_sample        r_median;
    logic [SUM_W-1:0]         r_abs_sum;
    logic                     r_sum_neg;

    // rank of every entry against the whole window
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            n_lt[i] = '0;
            n_gt[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if ($signed(i_win[j]) < $signed(i_win[i])) begin
                    n_lt[i] = n_lt[i] + RNK_W'(1);
                end
                if ($signed(i_win[j]) > $signed(i_win[i])) begin
                    n_gt[i] = n_gt[i] + RNK_W'(1);
                end
            end
            is_mid[i] = (n_lt[i] <= HALF) && (n_gt[i] <= HALF);
        end
    end

    // oldest qualifying entry wins
    always_comb begin
        median = i_win[0];
        for (int i = WINDOW - 1; i >= 0; i--) begin
            if (is_mid[i]) begin
                median = i_win[i];
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < WINDOW; i++) begin
            sum = sum + SUM_W'($signed(i_win[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last    <= i_ctl.last;
            r_median  <= median;
            r_sum_neg <= sum[SUM_W-1];
            r_abs_sum <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        end
    end

    assign o_ctl     = '{valid: r_valid, last: r_last};
    assign o_median  = r_median;
    assign o_abs_sum = r_abs_sum;
    assign o_sum_neg = r_sum_neg;

endmodule

/* rtl/wmmf_divsel.sv */
module wmmf_divsel #(
    parameter int WINDOW = 5
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_mode,
    input  wmmf_pkg::t_stage_ctl                    i_ctl,
    input  wmmf_pkg::t_sample                       i_median,
    input  logic [wmmf_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] i_abs_sum,
    input  logic                                    i_sum_neg,
    output logic                                    o_valid,
    output wmmf_pkg::t_out_item                     o_item
);

    localparam int SUM_W     = wmmf_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam longint unsigned MULT_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_FULL);

    logic [PROD_W-1:0]             prod;
    logic [wmmf_pkg::SAMPLE_W-1:0] quot;
    wmmf_pkg::t_sample             mean;
    logic                          r_valid;
    wmmf_pkg::t_out_item           r_item;

    // exact floor(abs / WINDOW) by reciprocal multiply
    assign prod = PROD_W'(i_abs_sum) * PROD_W'(MULT);
    assign quot = prod[DIV_SHIFT +: wmmf_pkg::SAMPLE_W];
    assign mean = i_sum_neg ? wmmf_pkg::t_sample'(-quot) : wmmf_pkg::t_sample'(quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.filtered  <= (i_mode == wmmf_pkg::MODE_MEAN) ? mean : i_median;
            r_item.final_res <= i_ctl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/window5_median_mean_filter.sv */
// window5_median_mean_filter
// streaming median / mean filter over a sliding window of WINDOW samples
// input channel: i_in_valid / o_in_stall carry one signed Q8.8 sample and a
//   last flag; a transaction completes when valid is high and stall is low
// output channel: o_out_valid / i_out_stall carry the filtered value and a
//   final_res flag marking the last result of a stream
// config channel: i_cfg_valid / o_cfg_ready write filter_mode (0 median,
//   1 mean); ready is always high, write only while the filter is idle
// the first WINDOW-1 samples of a stream only fill the history; each later
//   sample gives one result for the window centred WINDOW/2 samples back
// a sample flagged last restarts the history for the next stream
// a result reaches o_out_valid through the window register at the input edge,
//   the rank/sum register and the divide/select output register
// throughput: one sample per cycle when not stalled, the reciprocal multiply for the mean
//   and the parallel rank compare each fit in one stage
// when i_out_stall is high a valid output holds and stall backs up the pipeline;
//   o_in_stall rises only when all three stages hold results
// reset (i_rst_n low, synchronous) empties the pipeline, clears the history
//   count and selects median mode
module window5_median_mean_filter #(
    parameter int WINDOW = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wmmf_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wmmf_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data
);

    localparam int SUM_W = wmmf_pkg::SAMPLE_W + $clog2(WINDOW);

    logic                            r_filter_mode;
    logic                            en_win;
    logic                            en_stats;
    logic                            en_out;
    logic                            load;
    wmmf_pkg::t_stage_ctl            win_ctl;
    wmmf_pkg::t_sample [WINDOW-1:0]  win;
    wmmf_pkg::t_stage_ctl            stats_ctl;
    wmmf_pkg::t_sample               median;
    logic [SUM_W-1:0]                abs_sum;
    logic                            sum_neg;

    assign en_out     = !o_out_valid || !i_out_stall;
    assign en_stats   = !stats_ctl.valid || en_out;
    assign en_win     = !win_ctl.valid || en_stats;
    assign o_in_stall = !en_win;
    assign load       = i_in_valid && en_win;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= wmmf_pkg::MODE_MEDIAN;
        end else if (i_cfg_valid) begin
            r_filter_mode <= i_cfg_data;
        end
    end

    wmmf_window #(.WINDOW(WINDOW)) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_win),
        .i_load  (load),
        .i_in    (i_in_data),
        .o_ctl   (win_ctl),
        .o_win   (win)
    );

    wmmf_stats #(.WINDOW(WINDOW)) u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en_stats),
        .i_ctl     (win_ctl),
        .i_win     (win),
        .o_ctl     (stats_ctl),
        .o_median  (median),
        .o_abs_sum (abs_sum),
        .o_sum_neg (sum_neg)
    );

    wmmf_divsel #(.WINDOW(WINDOW)) u_divsel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en_out),
        .i_mode    (r_filter_mode),
        .i_ctl     (stats_ctl),
        .i_median  (median),
        .i_abs_sum (abs_sum),
        .i_sum_neg (sum_neg),
        .o_valid   (o_out_valid),
        .o_item    (o_out_data)
    );

endmodule
